/* design/sfd_pkg.sv */
// Shared constants, types and arithmetic helpers for the stereo feedback delay.
`default_nettype none

package sfd_pkg;

    localparam int DEPTH      = 65536;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int MIX_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = 34;
    localparam int FRAC_W     = 16;

    localparam logic [MIX_W-1:0] UNITY = MIX_W'(65536);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam prod_t SMAX = prod_t'((2 ** (SAMPLE_W - 1)) - 1);
    localparam prod_t SMIN = -SMAX - prod_t'(1);
    localparam prod_t HALF = prod_t'(2 ** (FRAC_W - 1));

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_DELAY  = 2'd1,
        REG_GAIN   = 2'd2,
        REG_WET    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [MIX_W-1:0]  wet;
        logic [MIX_W-1:0]  dry;
    } coef_t;

    typedef struct packed {
        logic adv;
        logic en;
    } stage_ctrl_t;

    // Q0.16 rounding: add one half, floor shift
    function automatic prod_t round16(input prod_t p);
        prod_t t;
        t = p + HALF;
        return t >>> FRAC_W;
    endfunction

    function automatic sample_t sat_sample(input prod_t v);
        sample_t r;
        if (v > SMAX) begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (v < SMIN) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/sfd_chan.sv */
// One channel: registered gain products, then round, sum and saturate; or bypass.
`default_nettype none

module sfd_chan
    import sfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire stage_ctrl_t ctrl,
    input  wire sample_t     x_in,
    input  wire sample_t     delayed,
    input  wire coef_t       coef,
    output sample_t          fb_out,
    output sample_t          y_out
);

    sample_t x_reg;
    prod_t   p_fb_reg;
    prod_t   p_dry_reg;
    prod_t   p_wet_reg;
    prod_t   fb_sum;
    sample_t y_mix;

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            x_reg     <= x_in;
            p_fb_reg  <= prod_t'(delayed) * prod_t'($signed({1'b0, coef.gain}));
            p_dry_reg <= prod_t'(x_in) * prod_t'($signed({1'b0, coef.dry}));
            p_wet_reg <= prod_t'(delayed) * prod_t'($signed({1'b0, coef.wet}));
        end
    end

    assign fb_sum = prod_t'(x_reg) + round16(p_fb_reg);
    assign fb_out = sat_sample(fb_sum);
    assign y_mix  = sat_sample(round16(p_dry_reg + p_wet_reg));
    assign y_out  = ctrl.en ? y_mix : x_reg;

endmodule

`default_nettype wire

/* design/stereo_feedback_delay.sv */
// Stereo feedback delay with wet/dry mix: top level, delay memory and pipeline control.
`default_nettype none

// Accepts one stereo frame per clock, unless m_tready holds the pipeline, and presents its
// mixed frame from the output register, after the stage-1 and gain product registers; the
// rate is set by the single 65536 x 32 delay memory, read once per frame and written once
// per enabled frame (read-modify-write across a 3-stage pipeline, with forwarding of the
// two most recent writes). The memory is not swept after reset: entries not yet written
// since reset read as zero, tracked by the write position and a wrap flag, so the block is
// ready right after reset. m_tready low while a result beat waits holds the whole pipeline
// and drops s_tready in the same cycle.
// Configuration writes are taken at any cycle but must only be issued while
// the block is idle.

module stereo_feedback_delay
    import sfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire cfg_reg_t              cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // left_in [15:0], right_in [31:16]

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata    // left_out [15:0], right_out [31:16]
);

    logic                enable_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [MIX_W-1:0]    wet_reg;

    logic [ADDR_W-1:0]   wi_reg;
    logic                wrapped_reg;

    logic                s1_valid_reg;
    logic                s1_en_reg;
    logic [ADDR_W-1:0]   s1_wi_reg;
    logic [ADDR_W-1:0]   s1_rd_reg;
    logic                s1_fresh_reg;
    sample_t             s1_xl_reg;
    sample_t             s1_xr_reg;
    logic [2*SAMPLE_W-1:0] rdata_reg;

    logic                s2_valid_reg;
    logic                s2_en_reg;
    logic [ADDR_W-1:0]   s2_wi_reg;

    logic                wb_valid_reg;
    logic [ADDR_W-1:0]   wb_addr_reg;
    logic [2*SAMPLE_W-1:0] wb_data_reg;

    logic                m_tvalid_reg;
    logic [31:0]         m_tdata_reg;

    logic [2*SAMPLE_W-1:0] line_mem [DEPTH];

    logic                adv;
    logic                acc;
    logic                wr_en;
    logic [ADDR_W-1:0]   dly;
    logic [ADDR_W-1:0]   rd;
    logic                fresh;
    logic [MIX_W-1:0]    wet_sat;
    coef_t               coef;
    stage_ctrl_t         chan_ctrl;
    logic                hit_s2;
    logic                hit_wb;
    logic [2*SAMPLE_W-1:0] delayed_word;
    logic [2*SAMPLE_W-1:0] fb_word;
    sample_t             fb_l;
    sample_t             fb_r;
    sample_t             y_l;
    sample_t             y_r;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;
    assign wr_en    = adv && s2_valid_reg && s2_en_reg;

    assign dly   = (32'(delay_reg) > 32'(DEPTH - 1)) ? ADDR_W'(DEPTH - 1) : ADDR_W'(delay_reg);
    assign rd    = wi_reg - dly;
    assign fresh = wrapped_reg || (rd < wi_reg);

    assign wet_sat = (wet_reg > UNITY) ? UNITY : wet_reg;
    assign coef    = {gain_reg, wet_sat, UNITY - wet_sat};

    assign fb_word = {fb_r, fb_l};
    assign hit_s2  = s2_valid_reg && s2_en_reg && (s2_wi_reg == s1_rd_reg);
    assign hit_wb  = wb_valid_reg && (wb_addr_reg == s1_rd_reg);

    always_comb begin
        if (hit_s2) begin
            delayed_word = fb_word;
        end else if (hit_wb) begin
            delayed_word = wb_data_reg;
        end else if (s1_fresh_reg) begin
            delayed_word = rdata_reg;
        end else begin
            delayed_word = '0;
        end
    end

    assign chan_ctrl = '{adv: adv, en: s2_en_reg};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            delay_reg  <= '0;
            gain_reg   <= '0;
            wet_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ENABLE: enable_reg <= cfg_wdata[0];
                REG_DELAY:  delay_reg  <= cfg_wdata[DELAY_W-1:0];
                REG_GAIN:   gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_WET:    wet_reg    <= cfg_wdata[MIX_W-1:0];
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    // write position and fill tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (acc && enable_reg) begin
            wi_reg <= wi_reg + ADDR_W'(1);
            if (wi_reg == ADDR_W'(DEPTH - 1)) begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // delay memory: one read per cycle while not stalled, one write per enabled frame
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[s2_wi_reg] <= fb_word;
        end
        if (adv) begin
            rdata_reg <= line_mem[rd];
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            wb_valid_reg <= wr_en;
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_en_reg    <= enable_reg;
            s1_wi_reg    <= wi_reg;
            s1_rd_reg    <= rd;
            s1_fresh_reg <= fresh;
            s1_xl_reg    <= s_tdata[SAMPLE_W-1:0];
            s1_xr_reg    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            s2_en_reg    <= s1_en_reg;
            s2_wi_reg    <= s1_wi_reg;
            wb_addr_reg  <= s2_wi_reg;
            wb_data_reg  <= fb_word;
            m_tdata_reg  <= {y_r, y_l};
        end
    end

    sfd_chan u_chan_l (
        .aclk    (aclk),
        .ctrl    (chan_ctrl),
        .x_in    (s1_xl_reg),
        .delayed (delayed_word[SAMPLE_W-1:0]),
        .coef    (coef),
        .fb_out  (fb_l),
        .y_out   (y_l)
    );

    sfd_chan u_chan_r (
        .aclk    (aclk),
        .ctrl    (chan_ctrl),
        .x_in    (s1_xr_reg),
        .delayed (delayed_word[2*SAMPLE_W-1:SAMPLE_W]),
        .coef    (coef),
        .fb_out  (fb_r),
        .y_out   (y_r)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_wi_step: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && enable_reg |=> wi_reg == $past(wi_reg) + ADDR_W'(1))
        else $error("write position did not advance on an enabled beat");

    a_wi_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !enable_reg |=> wi_reg == $past(wi_reg))
        else $error("write position moved while disabled");

    a_wrap_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag cleared without reset");

    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_en_reg && s2_valid_reg && s2_en_reg
            |-> s1_wi_reg == s2_wi_reg + ADDR_W'(1))
        else $error("adjacent stages hold non-consecutive write positions");

endmodule

`default_nettype wire
